### sv/q2e_pkg.sv
// Shared widths, constants, arctangent table and angle rounding for quaternion to Euler.
`default_nettype none
package q2e_pkg;

    localparam int QW           = 16;
    localparam int PW           = 32;
    localparam int CW           = 36;
    localparam int AW           = 34;
    localparam int RW           = 57;
    localparam int SQ_W         = 29;
    localparam int PM_W         = 28;
    localparam int SQRT_LAT     = 29;
    localparam int TAB_LEN      = 25;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [CW-1:0] ONE_Q28     = CW'(64'sd268435456);
    localparam logic signed [AW-1:0] ANG_PI      = AW'(64'sd3373259426);
    localparam logic signed [15:0]   OUT_PI      = 16'sd25736;
    localparam logic signed [15:0]   OUT_HALF_PI = 16'sd12868;

    localparam logic [AW-1:0] ATAN_TAB [TAB_LEN] = '{
        34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6, 34'h003FEAB76,
        34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55, 34'h0003FFFEA, 34'h0001FFFFD,
        34'h0000FFFFF, 34'h00007FFFF, 34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF,
        34'h000007FFF, 34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
        34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F, 34'h00000003F
    };

    typedef struct packed {
        logic clamped;
        logic neg;
    } t_pitch_flags;

    typedef struct packed {
        logic signed [CW-1:0] roll_s;
        logic signed [CW-1:0] roll_c;
        logic signed [CW-1:0] yaw_s;
        logic signed [CW-1:0] yaw_c;
        logic signed [CW-1:0] pitch_p;
        t_pitch_flags         flags;
    } t_side;

    // round half up to Q3.13 and saturate to +/- lim
    function automatic logic signed [15:0] to_q13(input logic signed [AW-1:0] ang,
                                                  input logic signed [15:0] lim);
        logic signed [AW-1:0] sum;
        logic signed [16:0]   r;
        begin
            sum = ang + AW'(65536);
            r   = 17'(sum >>> 17);
            if (r > 17'(lim)) begin
                r = 17'(lim);
            end else if (r < -17'(lim)) begin
                r = -17'(lim);
            end
            to_q13 = r[15:0];
        end
    endfunction

endpackage
`default_nettype wire

### sv/quaternion_to_euler_angles.sv
// Top level: quaternion to ZYX Euler angles, fully pipelined.
// Stages: 3 product stages, 29 square-root stages, CORDIC_STEPS + 1 arctangent stages,
// 1 rounding stage.
// Throughput: one request per cycle; the whole pipeline holds while the output stalls.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`default_nettype none
module quaternion_to_euler_angles import q2e_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic signed [15:0]    i_quat_w,
    input  wire logic signed [15:0]    i_quat_x,
    input  wire logic signed [15:0]    i_quat_y,
    input  wire logic signed [15:0]    i_quat_z,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [15:0]         o_roll_angle,
    output logic signed [14:0]         o_pitch_angle,
    output logic signed [15:0]         o_yaw_angle,
    output logic                       o_pitch_clamped
);
    localparam int CLAT = CORDIC_STEPS + 1;

    logic en;
    logic prod_valid, sqrt_valid, roll_valid, pitch_valid, yaw_valid;
    t_side prod_side;
    logic [RW-1:0] prod_rad;
    logic [SQ_W-1:0] root;
    logic signed [AW-1:0] roll_ang, pitch_ang, yaw_ang;
    t_side        r_side  [SQRT_LAT];
    t_pitch_flags r_flags [CLAT];
    t_pitch_flags fl;
    logic signed [15:0] pitch_q;

    logic r_valid;
    logic signed [15:0] r_roll, r_yaw;
    logic signed [14:0] r_pitch;
    logic r_clamped;

    assign en      = !r_valid || !i_stall;
    assign o_stall = !en;

    q2e_products u_prod (
        .i_clk, .i_rst_n, .i_en(en), .i_valid,
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .o_valid(prod_valid), .o_side(prod_side), .o_rad(prod_rad)
    );

    q2e_isqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(prod_valid),
        .i_rad(prod_rad), .o_valid(sqrt_valid), .o_root(root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= prod_side;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_flags[0] <= r_side[SQRT_LAT-1].flags;
            for (int k = 1; k < CLAT; k++) begin
                r_flags[k] <= r_flags[k-1];
            end
        end
    end

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(sqrt_valid),
        .i_y(r_side[SQRT_LAT-1].roll_s), .i_x(r_side[SQRT_LAT-1].roll_c),
        .o_valid(roll_valid), .o_angle(roll_ang)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(sqrt_valid),
        .i_y(r_side[SQRT_LAT-1].pitch_p), .i_x(CW'(root)),
        .o_valid(pitch_valid), .o_angle(pitch_ang)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(sqrt_valid),
        .i_y(r_side[SQRT_LAT-1].yaw_s), .i_x(r_side[SQRT_LAT-1].yaw_c),
        .o_valid(yaw_valid), .o_angle(yaw_ang)
    );

    always_comb begin
        fl = r_flags[CLAT-1];
        if (fl.clamped) begin
            pitch_q = fl.neg ? -OUT_HALF_PI : OUT_HALF_PI;
        end else begin
            pitch_q = to_q13(pitch_ang, OUT_HALF_PI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= roll_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll    <= to_q13(roll_ang, OUT_PI);
            r_yaw     <= to_q13(yaw_ang, OUT_PI);
            r_pitch   <= pitch_q[14:0];
            r_clamped <= fl.clamped;
        end
    end

    assign o_valid         = r_valid;
    assign o_roll_angle    = r_roll;
    assign o_pitch_angle   = r_pitch;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_clamped = r_clamped;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (roll_valid == pitch_valid) && (roll_valid == yaw_valid))
        else $error("CORDIC lanes out of step");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pitch_clamped) |->
        (o_pitch_angle == 15'sd12868 || o_pitch_angle == -15'sd12868))
        else $error("clamped pitch not at half pi");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= OUT_PI && o_roll_angle >= -OUT_PI &&
                     o_yaw_angle <= OUT_PI && o_yaw_angle >= -OUT_PI))
        else $error("angle out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_roll_angle) && $stable(o_yaw_angle)))
        else $error("stalled result changed");
endmodule
`default_nettype wire

### sv/q2e_products.sv
// Product terms, sums, pitch range check and square-root radicand (three stages).
`default_nettype none
module q2e_products import q2e_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic signed [QW-1:0]  i_quat_w,
    input  wire logic signed [QW-1:0]  i_quat_x,
    input  wire logic signed [QW-1:0]  i_quat_y,
    input  wire logic signed [QW-1:0]  i_quat_z,
    output logic                       o_valid,
    output t_side                      o_side,
    output logic [RW-1:0]              o_rad
);
    logic [2:0] r_vld;
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_side r_side2, r_side3;
    logic [PM_W-1:0] r_pm;
    logic [RW-1:0] r_rad;

    logic signed [CW-1:0] n_p, p_abs;
    logic n_clamp;
    logic [2*PM_W-1:0] pm_sq;

    always_comb begin
        n_p     = (CW'(r_wy) - CW'(r_zx)) <<< 1;
        n_clamp = (n_p >= ONE_Q28) || (n_p <= -ONE_Q28);
        p_abs   = n_p[CW-1] ? -n_p : n_p;
        pm_sq   = r_pm * r_pm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;

            r_side2.roll_s        <= (CW'(r_wx) + CW'(r_yz)) <<< 1;
            r_side2.roll_c        <= ONE_Q28 - ((CW'(r_xx) + CW'(r_yy)) <<< 1);
            r_side2.yaw_s         <= (CW'(r_wz) + CW'(r_xy)) <<< 1;
            r_side2.yaw_c         <= ONE_Q28 - ((CW'(r_yy) + CW'(r_zz)) <<< 1);
            r_side2.pitch_p       <= n_p;
            r_side2.flags.clamped <= n_clamp;
            r_side2.flags.neg     <= n_p[CW-1];
            r_pm                  <= n_clamp ? '0 : p_abs[PM_W-1:0];

            r_side3 <= r_side2;
            r_rad   <= {1'b1, {(RW-1){1'b0}}} - {1'b0, pm_sq};
        end
    end

    assign o_valid = r_vld[2];
    assign o_side  = r_side3;
    assign o_rad   = r_rad;
endmodule
`default_nettype wire

### sv/q2e_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module q2e_isqrt import q2e_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [RW-1:0]    i_rad,
    output logic                  o_valid,
    output logic [SQ_W-1:0]       o_root
);
    logic [SQRT_LAT-1:0] r_vld;
    logic [RW-1:0] r_v   [SQRT_LAT];
    logic [RW-1:0] r_res [SQRT_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_LAT-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (RW - 1 - 2 * k);
        logic [RW-1:0] v_in, res_in, trial;
        if (k == 0) begin : g_first
            assign v_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign res_in = r_res[k-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= trial) begin
                    r_v[k]   <= v_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_v[k]   <= v_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[SQRT_LAT-1];
    assign o_root  = r_res[SQRT_LAT-1][SQ_W-1:0];
endmodule
`default_nettype wire

### sv/q2e_cordic.sv
// Pipelined vectoring CORDIC arctangent, one iteration per stage.
`default_nettype none
module q2e_cordic import q2e_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic signed [CW-1:0]  i_y,
    input  wire logic signed [CW-1:0]  i_x,
    output logic                       o_valid,
    output logic signed [AW-1:0]       o_angle
);
    logic [STEPS:0] r_vld;
    logic                 r_zero [STEPS+1];
    logic signed [CW-1:0] r_x    [STEPS+1];
    logic signed [CW-1:0] r_y    [STEPS+1];
    logic signed [AW-1:0] r_z    [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STEPS-1:0], i_valid};
        end
    end

    // left half plane folds by half a turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[CW-1]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= i_y[CW-1] ? -ANG_PI : ANG_PI;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        localparam logic signed [AW-1:0] ATN = ATAN_TAB[i];
        logic signed [CW-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_y[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ATN;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ATN;
                end
            end
        end
    end

    assign o_valid = r_vld[STEPS];
    assign o_angle = r_zero[STEPS] ? '0 : r_z[STEPS];
endmodule
`default_nettype wire

### verif/quaternion_to_euler_angles_test.sv
// Self-checking testbench for quaternion_to_euler_angles: directed table plus random quaternions.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_test;
    import q2e_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int LATENCY = STEPS + 34;
    localparam int N_RANDOM = 500;
    localparam int N_DIRECTED = 20;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_angles;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic               known;
        t_angles            ang;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [15:0] i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic o_stall, o_valid, o_pitch_clamped;
    logic signed [15:0] o_roll_angle, o_yaw_angle;
    logic signed [14:0] o_pitch_angle;

    quaternion_to_euler_angles uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .o_valid(o_valid), .i_stall(i_stall),
        .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle),
        .o_yaw_angle(o_yaw_angle), .o_pitch_clamped(o_pitch_clamped)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_angles expected_angles[$];
    int mismatches = 0;
    bit sending_done = 0;
    bit calm = 0;

    longint arctan_tab [25] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F
    };

    function automatic longint vector_angle(longint sy, longint sx);
        longint acc, xs, ys;
        int n;
        acc = 0;
        n = (STEPS > 25) ? 25 : STEPS;
        if (sx == 0 && sy == 0) return 0;
        if (sx < 0) begin
            acc = (sy >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            sx = -sx;
            sy = -sy;
        end
        for (int i = 0; i < n; i++) begin
            xs = sx >>> i;
            ys = sy >>> i;
            if (sy >= 0) begin
                sx += ys; sy -= xs; acc += arctan_tab[i];
            end else begin
                sx -= ys; sy += xs; acc -= arctan_tab[i];
            end
        end
        return acc;
    endfunction

    function automatic longint round_q13(longint a, longint lim);
        longint r;
        r = (a + 65536) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint root_floor(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'sd268435456;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid; else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_angles euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                         logic signed [15:0] qy, logic signed [15:0] qz);
        t_angles e;
        longint w, x, y, z, s, c, p, r;
        w = qw; x = qx; y = qy; z = qz;
        s = 2 * (w * x + y * z);
        c = 64'sd268435456 - 2 * (x * x + y * y);
        e.roll = 16'(round_q13(vector_angle(s, c), 25736));
        p = 2 * (w * y - z * x);
        if (p >= 64'sd268435456 || p <= -64'sd268435456) begin
            e.pitch = (p > 0) ? 15'sd12868 : -15'sd12868;
            e.clamped = 1'b1;
        end else begin
            r = root_floor((64'sd1 << 56) - p * p);
            e.pitch = 15'(round_q13(vector_angle(p, r), 12868));
            e.clamped = 1'b0;
        end
        s = 2 * (w * z + x * y);
        c = 64'sd268435456 - 2 * (y * y + z * z);
        e.yaw = 16'(round_q13(vector_angle(s, c), 25736));
        return e;
    endfunction

    // identity, zero, pure x/z and clamped rows have hand answers; the rest use the predictor
    t_row directed [N_DIRECTED] = '{
        '{16'sd16384, 0, 0, 0, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
        '{0, 0, 0, 0, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
        '{0, 16'sd16384, 0, 0, 1'b1, '{16'sd25736, 15'sd0, 16'sd0, 1'b0}},
        '{0, 0, 0, 16'sd16384, 1'b1, '{16'sd0, 15'sd0, 16'sd25736, 1'b0}},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{0, 0, 0, 0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '{0, 0, 0, 0}},
        '{16'sd32767, 0, 16'sd32767, 0, 1'b1, '{16'sd25736, 15'sd12868, 16'sd25736, 1'b1}},
        '{16'sd32767, 0, -16'sd32768, 0, 1'b0, '{0, 0, 0, 0}},
        '{16'sd11585, 0, 16'sd11585, 0, 1'b0, '{0, 0, 0, 0}},
        '{16'sd11585, 0, -16'sd11585, 0, 1'b0, '{0, 0, 0, 0}},
        '{16'sd11585, 16'sd11585, 0, 0, 1'b0, '{0, 0, 0, 0}},
        '{16'sd11585, 0, 0, -16'sd11585, 1'b0, '{0, 0, 0, 0}},
        '{0, 16'sd16384, 16'sd16384, 0, 1'b0, '{0, 0, 0, 0}},
        '{0, -16'sd16384, 0, 16'sd16384, 1'b0, '{0, 0, 0, 0}},
        '{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 1'b0, '{0, 0, 0, 0}},
        '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, '{0, 0, 0, 0}},
        '{-16'sd1, 16'sd32767, -16'sd32768, 16'sd1, 1'b0, '{0, 0, 0, 0}},
        '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, '{0, 0, 0, 0}},
        '{16'sd16384, 16'sd5461, -16'sd9000, 16'sd12000, 1'b0, '{0, 0, 0, 0}},
        '{16'sh5555, -16'sh5556, 16'sh2AAA, -16'sh2AAB, 1'b0, '{0, 0, 0, 0}}
    };

    function automatic logic signed [15:0] rand_component();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return ($urandom_range(0, 1)) ? 16'sd32767 : -16'sd32768;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // one request, with an optional idle gap ahead of it
    task automatic send_request(logic signed [15:0] w, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic report(string what, t_angles e);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: exp roll %0d pitch %0d yaw %0d clamp %0b, got %0d %0d %0d %0b",
                     what, e.roll, e.pitch, e.yaw, e.clamped, o_roll_angle,
                     o_pitch_angle, o_yaw_angle, o_pitch_clamped);
    endtask

    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && i_valid && !o_stall) begin
            e = euler_of(i_quat_w, i_quat_x, i_quat_y, i_quat_z);
            expected_angles.push_back(e);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_angles.size() == 0) begin
                report("unexpected result", e);
            end else begin
                e = expected_angles.pop_front();
                if (o_roll_angle !== e.roll || o_pitch_angle !== e.pitch ||
                    o_yaw_angle !== e.yaw || o_pitch_clamped !== e.clamped)
                    report("angles", e);
            end
        end
    end

    initial begin
        int left;
        @(negedge i_clk);
        while (!sending_done || !calm) begin
            left = $urandom_range(1, 15);
            if (!calm && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat (left) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (left) @(negedge i_clk);
        end
        i_stall <= 1'b0;
    end

    initial begin
        t_angles hand;
        int waited;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[k]) begin
            if (directed[k].known) begin
                hand = euler_of(directed[k].w, directed[k].x, directed[k].y, directed[k].z);
                if (hand.roll !== directed[k].ang.roll ||
                    hand.pitch !== directed[k].ang.pitch ||
                    hand.yaw !== directed[k].ang.yaw ||
                    hand.clamped !== directed[k].ang.clamped) begin
                    mismatches++;
                    $display("directed row %0d disagrees with predictor", k);
                end
            end
            send_request(directed[k].w, directed[k].x, directed[k].y, directed[k].z);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM * 4 / 5) calm = 1;
            send_request(rand_component(), rand_component(), rand_component(),
                         rand_component());
        end
        i_valid <= 1'b0;
        sending_done = 1;
        calm = 1;
        waited = 0;
        while (expected_angles.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
